@@ rtl/core/gbn_pkg.sv @@
// Shared types, constants and helper functions of the Go-Back-N sender window.
package gbn_pkg;

  localparam int WINDOW       = 4;
  localparam int SEQ_SPACE    = 8;
  localparam int PAYLOAD_BITS = 32;

  localparam int SEQ_W  = $clog2(SEQ_SPACE);
  localparam int RING_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CMP_W  = (SEQ_W > CNT_W) ? SEQ_W : CNT_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SEQ_W-1:0]        seq_t;
  typedef logic [RING_W-1:0]       ring_idx_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_SENT     = 3'd0,
    ST_FULL     = 3'd1,
    ST_ACK_OK   = 3'd2,
    ST_ACK_DROP = 3'd3,
    ST_RETX     = 3'd4,
    ST_BAD_TO   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    op_t      op;
    payload_t payload;
    seq_t     ack_num;
    logic     ack_intact;
    seq_t     timed_out_seq;
  } gbn_in_t;

  typedef struct packed {
    status_t  status;
    logic     pkt_valid;
    seq_t     pkt_seq;
    payload_t pkt_payload;
    logic     timer_stop;
    seq_t     stop_seq;
    logic     timer_start;
    seq_t     start_seq;
    logic     window_full;
    logic     last;
  } gbn_out_t;

  // One command from the front end to the back end. Single-result items carry
  // their finished result; a retransmit burst carries its base, ring start and
  // length. A send also writes its payload into the ring at slot.
  typedef struct packed {
    logic      retx;
    logic      ring_wr;
    ring_idx_t slot;
    count_t    cnt;
    seq_t      base;
    gbn_out_t  res;
  } gbn_cmd_t;

  // Sequence number plus one, modulo the sequence space.
  function automatic seq_t seq_inc(input seq_t s);
    if (s == SEQ_W'(SEQ_SPACE - 1)) begin
      return '0;
    end
    return s + SEQ_W'(1);
  endfunction

  // Ring index plus an offset of at most WINDOW, modulo WINDOW.
  function automatic ring_idx_t ring_add(input ring_idx_t a, input count_t b);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (sum >= (CNT_W + 1)'(WINDOW)) begin
      sum = sum - (CNT_W + 1)'(WINDOW);
    end
    return sum[RING_W-1:0];
  endfunction

endpackage

@@ rtl/core/go_back_n_sender_window_unit.sv @@
// Top level of the Go-Back-N sender window: front end, command queue, back end.
//
//   Channel   Direction  Handshake             Payload
//   in_*      input      in_valid / in_stall   gbn_in_t  (op, payload, ack, timeout seq)
//   out_*     output     out_valid / out_stall gbn_out_t (status, packet, timer, flags)
//
// Sends, acks and rejected items produce one result each and sustain one
// transaction per cycle through the front end, the two-entry queue and the
// output register while out_stall is low and no retransmit burst holds the
// back end. Such a result enters the queue at the edge that accepts its item
// and is loaded from the queue head into the output register. A timeout burst
// of N retransmissions takes the command, then for each packet fetches from
// the registered read port of the payload ring and emits into the output register.
// Reset (rst_n low, synchronous) sets the base and next sequence number to one,
// empties the window, the queue and the output register; the payload ring is
// not cleared. in_stall rises only when the command queue is full, and a high
// out_stall holds the output register and, behind it, the back end.
module go_back_n_sender_window_unit import gbn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gbn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output gbn_out_t out_data
);

  // Commands flow from the front end through the queue to the back end.
  logic     q_push;
  logic     q_full;
  gbn_cmd_t q_push_cmd;
  logic     q_pop;
  logic     q_not_empty;
  gbn_cmd_t q_head_cmd;

  // The front end owns the window state: it decides every outcome at accept
  // time, so the back end only replays results and writes and reads the payload ring.
  gbn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  gbn_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head_cmd)
  );

  // The ring is written and read only by the back end, in command order, so a
  // later send can never overwrite a payload that an earlier timeout replays.
  gbn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (q_head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

@@ rtl/core/gbn_front.sv @@
// Front end: accepts items, tracks the window state and issues commands.
module gbn_front import gbn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gbn_in_t  in_data,
  input  logic     q_full,
  output logic     q_push,
  output gbn_cmd_t q_cmd
);

  seq_t      base_r, base_nxt;
  seq_t      next_seq_r, next_seq_nxt;
  count_t    cnt_r, cnt_nxt;
  ring_idx_t head_r, head_nxt;
  logic      wait_r, wait_nxt;

  seq_t   offset;
  count_t freed;
  count_t cnt_after;
  seq_t   new_base;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    base_nxt     = base_r;
    next_seq_nxt = next_seq_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    wait_nxt     = wait_r;

    // Distance of the acknowledged number from the base, modulo the space.
    if (in_data.ack_num >= base_r) begin
      offset = in_data.ack_num - base_r;
    end else begin
      offset = SEQ_W'((SEQ_W + 1)'(in_data.ack_num) + (SEQ_W + 1)'(SEQ_SPACE)
                      - (SEQ_W + 1)'(base_r));
    end
    freed     = CNT_W'(offset) + CNT_W'(1);
    cnt_after = cnt_r - freed;
    new_base  = seq_inc(in_data.ack_num);

    q_cmd                 = '0;
    q_cmd.res.status      = ST_ACK_DROP;
    q_cmd.res.window_full = wait_r;
    q_cmd.res.last        = 1'b1;

    case (in_data.op)
      OP_SEND: begin
        if (cnt_r >= CNT_W'(WINDOW)) begin
          q_cmd.res.status = ST_FULL;
        end else begin
          next_seq_nxt          = seq_inc(next_seq_r);
          cnt_nxt               = cnt_r + CNT_W'(1);
          wait_nxt              = (cnt_nxt >= CNT_W'(WINDOW));
          q_cmd.ring_wr         = 1'b1;
          q_cmd.slot            = ring_add(head_r, cnt_r);
          q_cmd.res.status      = ST_SENT;
          q_cmd.res.pkt_valid   = 1'b1;
          q_cmd.res.pkt_seq     = next_seq_r;
          q_cmd.res.pkt_payload = in_data.payload;
          q_cmd.res.timer_start = (cnt_r == '0);
          q_cmd.res.start_seq   = (cnt_r == '0) ? next_seq_r : '0;
          q_cmd.res.window_full = wait_nxt;
        end
      end
      OP_ACK: begin
        if (in_data.ack_intact && cnt_r != '0 && CMP_W'(offset) < CMP_W'(cnt_r)) begin
          base_nxt              = new_base;
          head_nxt              = ring_add(head_r, freed);
          cnt_nxt               = cnt_after;
          wait_nxt              = 1'b0;
          q_cmd.res.status      = ST_ACK_OK;
          q_cmd.res.timer_stop  = 1'b1;
          q_cmd.res.stop_seq    = base_r;
          q_cmd.res.timer_start = (cnt_after != '0);
          q_cmd.res.start_seq   = (cnt_after != '0) ? new_base : '0;
          q_cmd.res.window_full = 1'b0;
        end
      end
      OP_TIMEOUT: begin
        if (in_data.timed_out_seq == base_r && cnt_r != '0) begin
          q_cmd.retx = 1'b1;
          q_cmd.slot = head_r;
          q_cmd.cnt  = cnt_r;
          q_cmd.base = base_r;
        end else begin
          q_cmd.res.status = ST_BAD_TO;
        end
      end
      default: begin
        q_cmd.res.status = ST_ACK_DROP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= SEQ_W'(1 % SEQ_SPACE);
      next_seq_r <= SEQ_W'(1 % SEQ_SPACE);
      cnt_r      <= '0;
      head_r     <= '0;
      wait_r     <= 1'b0;
    end else if (q_push) begin
      base_r     <= base_nxt;
      next_seq_r <= next_seq_nxt;
      cnt_r      <= cnt_nxt;
      head_r     <= head_nxt;
      wait_r     <= wait_nxt;
    end
  end

endmodule

@@ rtl/core/gbn_cmd_queue.sv @@
// Short command queue between the front end and the back end.
module gbn_cmd_queue import gbn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  gbn_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output gbn_cmd_t head_cmd
);

  gbn_cmd_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;

  logic do_push, do_pop;

  assign full      = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign head_cmd  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/gbn_back.sv @@
// Back end: payload ring, retransmit sequencer and output register.
module gbn_back import gbn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_not_empty,
  input  gbn_cmd_t q_cmd,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output gbn_out_t out_data
);

  payload_t ring_mem [WINDOW];
  payload_t rdata_r;

  bk_state_t state_r, state_nxt;
  ring_idx_t idx_r, idx_nxt;
  seq_t      seq_r, seq_nxt;
  seq_t      base_r, base_nxt;
  count_t    rem_r, rem_nxt;
  logic      first_r, first_nxt;
  logic      wf_r, wf_nxt;

  logic     out_valid_r;
  gbn_out_t out_data_r;

  logic     load_ok;
  logic     load;
  gbn_out_t load_data;
  logic     mem_we;

  assign load_ok   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    seq_nxt   = seq_r;
    base_nxt  = base_r;
    rem_nxt   = rem_r;
    first_nxt = first_r;
    wf_nxt    = wf_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    load_data = q_cmd.res;
    mem_we    = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          if (q_cmd.retx) begin
            q_pop     = 1'b1;
            idx_nxt   = q_cmd.slot;
            seq_nxt   = q_cmd.base;
            base_nxt  = q_cmd.base;
            rem_nxt   = q_cmd.cnt;
            first_nxt = 1'b1;
            wf_nxt    = q_cmd.res.window_full;
            state_nxt = BK_READ;
          end else if (load_ok) begin
            q_pop  = 1'b1;
            load   = 1'b1;
            mem_we = q_cmd.ring_wr;
          end
        end
      end
      BK_READ: begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        load_data             = '0;
        load_data.status      = ST_RETX;
        load_data.pkt_valid   = 1'b1;
        load_data.pkt_seq     = seq_r;
        load_data.pkt_payload = rdata_r;
        load_data.timer_stop  = first_r;
        load_data.stop_seq    = first_r ? base_r : '0;
        load_data.timer_start = first_r;
        load_data.start_seq   = first_r ? base_r : '0;
        load_data.window_full = wf_r;
        load_data.last        = (rem_r == CNT_W'(1));
        if (load_ok) begin
          load      = 1'b1;
          first_nxt = 1'b0;
          rem_nxt   = rem_r - CNT_W'(1);
          idx_nxt   = ring_add(idx_r, CNT_W'(1));
          seq_nxt   = seq_inc(seq_r);
          state_nxt = (rem_r == CNT_W'(1)) ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[q_cmd.slot] <= q_cmd.res.pkt_payload;
    end
    rdata_r <= ring_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    seq_r   <= seq_nxt;
    base_r  <= base_nxt;
    rem_r   <= rem_nxt;
    first_r <= first_nxt;
    wf_r    <= wf_nxt;
    if (load) begin
      out_data_r <= load_data;
    end
  end

endmodule

@@ rtl/core/gbn_checker.sv @@
// Port-level assertions for the Go-Back-N sender window and their bind.
module gbn_checker import gbn_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input gbn_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_pkt_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pkt_valid |->
      (out_data.status == ST_SENT || out_data.status == ST_RETX))
    else $error("packet carried by a result that sends nothing");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_RETX |-> out_data.last)
    else $error("single-result transaction not marked last");

  a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timer_stop |->
      (out_data.status == ST_ACK_OK || out_data.status == ST_RETX))
    else $error("timer stop on a result that frees or replays nothing");

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
